// ===== rtl/core/mm4_pkg.sv =====
// shared types, constants and microcode program of the matrix multiplier
package mm4_pkg;

	localparam int DIM_DEF  = 4;
	localparam int FRAC_DEF = 16;
	localparam int DATA_W   = 32;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int PC_W     = 3;

	// program steps
	localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] STEP_RD    = 3'd1;
	localparam logic [PC_W-1:0] STEP_WAIT1 = 3'd2;
	localparam logic [PC_W-1:0] STEP_WAIT2 = 3'd3;
	localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;

	// jump conditions
	localparam logic [1:0] CND_NEVER     = 2'd0;
	localparam logic [1:0] CND_GO        = 2'd1;
	localparam logic [1:0] CND_K_LAST    = 2'd2;
	localparam logic [1:0] CND_CELL_LAST = 2'd3;

	typedef struct packed {
		logic [1:0]      cond;
		logic [PC_W-1:0] jmp;
		logic [PC_W-1:0] nxt;
		logic            clr_acc;
		logic            rd;
		logic            emit;
	} ucode_t;

	typedef struct packed {
		logic clr_acc;
		logic rd;
		logic emit;
		logic last;
	} ctl_t;

	// control store: jump to jmp when cond holds, else go to nxt
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		begin
			unique case (pc)
				STEP_IDLE: begin
					w = '{cond: CND_GO, jmp: STEP_RD, nxt: STEP_IDLE,
						clr_acc: 1'b1, rd: 1'b0, emit: 1'b0};
				end
				STEP_RD: begin
					w = '{cond: CND_K_LAST, jmp: STEP_WAIT1, nxt: STEP_RD,
						clr_acc: 1'b0, rd: 1'b1, emit: 1'b0};
				end
				STEP_WAIT1: begin
					w = '{cond: CND_NEVER, jmp: STEP_IDLE, nxt: STEP_WAIT2,
						clr_acc: 1'b0, rd: 1'b0, emit: 1'b0};
				end
				STEP_WAIT2: begin
					w = '{cond: CND_NEVER, jmp: STEP_IDLE, nxt: STEP_EMIT,
						clr_acc: 1'b0, rd: 1'b0, emit: 1'b0};
				end
				STEP_EMIT: begin
					w = '{cond: CND_CELL_LAST, jmp: STEP_IDLE, nxt: STEP_RD,
						clr_acc: 1'b1, rd: 1'b0, emit: 1'b1};
				end
				default: begin
					w = '{cond: CND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE,
						clr_acc: 1'b1, rd: 1'b0, emit: 1'b0};
				end
			endcase
			return w;
		end
	endfunction

endpackage

// ===== rtl/core/mm4_ram.sv =====
// generic single-write ram with registered read
module mm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mm4_seq.sv =====
// microcoded sequencer: step counter, control store and index counters
module mm4_seq #(
	parameter int DIM = mm4_pkg::DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	output logic                         busy,
	output mm4_pkg::ctl_t                ctl,
	output logic [$clog2(DIM)-1:0]       row,
	output logic [$clog2(DIM)-1:0]       col,
	output logic [$clog2(DIM*DIM)-1:0]   l_addr,
	output logic [$clog2(DIM*DIM)-1:0]   r_addr
);

	import mm4_pkg::*;

	localparam int IDX_W  = $clog2(DIM);
	localparam int CELL_W = $clog2(DIM*DIM);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

	logic [PC_W-1:0]  pc_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	ucode_t           w;
	logic             k_last;
	logic             cell_last;
	logic             hit;

	assign w         = ucode_rom(pc_q);
	assign k_last    = (k_q == IDX_LAST);
	assign cell_last = (row_q == IDX_LAST) && (col_q == IDX_LAST);

	always_comb begin
		unique case (w.cond)
			CND_NEVER:     hit = 1'b0;
			CND_GO:        hit = go;
			CND_K_LAST:    hit = k_last;
			CND_CELL_LAST: hit = cell_last;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= STEP_IDLE;
			k_q   <= '0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			pc_q <= hit ? w.jmp : w.nxt;
			if (w.rd) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end
			if (w.emit) begin
				if (col_q == IDX_LAST) begin
					col_q <= '0;
					row_q <= (row_q == IDX_LAST) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign l_addr = CELL_W'(int'(row_q) * DIM + int'(k_q));
	assign r_addr = CELL_W'(int'(k_q) * DIM + int'(col_q));

	assign ctl.clr_acc = w.clr_acc;
	assign ctl.rd      = w.rd;
	assign ctl.emit    = w.emit;
	assign ctl.last    = cell_last;

	assign busy = (pc_q != STEP_IDLE);
	assign row  = row_q;
	assign col  = col_q;

endmodule

// ===== rtl/core/mm4_dp.sv =====
// multiply-accumulate datapath with floor shift, saturation and result registers
module mm4_dp #(
	parameter int DIM       = mm4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mm4_pkg::FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mm4_pkg::ctl_t                      ctl,
	input  logic [$clog2(DIM)-1:0]             row,
	input  logic [$clog2(DIM)-1:0]             col,
	input  logic signed [mm4_pkg::DATA_W-1:0]  l_data,
	input  logic signed [mm4_pkg::DATA_W-1:0]  r_data,
	output logic                               result_strobe,
	output logic signed [mm4_pkg::DATA_W-1:0]  result_value,
	output logic [$clog2(DIM)-1:0]             result_row,
	output logic [$clog2(DIM)-1:0]             result_col,
	output logic                               saturated,
	output logic                               last_result
);

	import mm4_pkg::*;

	localparam int IDX_W = $clog2(DIM);
	localparam int ACC_W = PROD_W + $clog2(DIM);
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic                     rd_s1;
	logic                     mul_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sh;
	logic [ACC_W-DATA_W:0]    upper;
	logic                     ovf;
	logic signed [DATA_W-1:0] clipped;

	logic                     strobe_q;
	logic                     last_q;
	logic signed [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic                     sat_q;

	// ram data is registered in the ram after the read step, then the product in prod_s2; rd_s1 and mul_s2 follow them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1  <= 1'b0;
			mul_s2 <= 1'b0;
		end else begin
			rd_s1  <= ctl.rd;
			mul_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= l_data * r_data;
		if (ctl.clr_acc) begin
			acc_q <= '0;
		end else if (mul_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// arithmetic shift is a floor divide; clip when the upper bits disagree
	assign sh      = acc_q >>> FRAC_BITS;
	assign upper   = sh[ACC_W-1:DATA_W-1];
	assign ovf     = !((&upper) || (~|upper));
	assign clipped = ovf ? (sh[ACC_W-1] ? SAT_MIN : SAT_MAX) : sh[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
			last_q   <= ctl.emit && ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			value_q <= clipped;
			row_q   <= row;
			col_q   <= col;
			sat_q   <= ovf;
		end
	end

	assign result_strobe = strobe_q;
	assign result_value  = value_q;
	assign result_row    = row_q;
	assign result_col    = col_q;
	assign saturated     = sat_q;
	assign last_result   = last_q;

endmodule

// ===== rtl/core/matrix_multiply_4x4.sv =====
// top level of the fixed-point matrix multiplier
//
//  channel  | handshake                | beat
//  ---------+--------------------------+--------------------------------------------
//  element  | start in, busy out       | element_pos, element_value, start_req
//  result   | result_strobe out        | result_value, result_row, result_col,
//           |                          | saturated, last_result
//
// an element beat is taken whenever busy is low; a beat with start_req
// runs the product: one shared multiply-accumulate unit steps through the dot
// products, with DIM reads, then the WAIT1, WAIT2 and EMIT steps per result,
// paced by the single read port of each element ram.
// results are registered at each EMIT step and cannot be held off; busy falls as the
// last one is registered. reset clears the sequencer, not the element rams.
module matrix_multiply_4x4 #(
	parameter int DIM       = mm4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mm4_pkg::FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [$clog2(2*DIM*DIM)-1:0]        element_pos,
	input  logic signed [mm4_pkg::DATA_W-1:0]   element_value,
	input  logic                                start_req,
	output logic                                result_strobe,
	output logic signed [mm4_pkg::DATA_W-1:0]   result_value,
	output logic [$clog2(DIM)-1:0]              result_row,
	output logic [$clog2(DIM)-1:0]              result_col,
	output logic                                saturated,
	output logic                                last_result
);

	import mm4_pkg::*;

	localparam int CELLS  = DIM * DIM;
	localparam int POS_W  = $clog2(2 * CELLS);
	localparam int IDX_W  = $clog2(DIM);
	localparam int CELL_W = $clog2(CELLS);

	logic              accept;
	logic              go;
	logic              l_we;
	logic              r_we;
	logic [CELL_W-1:0] l_waddr;
	logic [CELL_W-1:0] r_waddr;
	logic [CELL_W-1:0] l_raddr;
	logic [CELL_W-1:0] r_raddr;
	logic [DATA_W-1:0] l_rdata;
	logic [DATA_W-1:0] r_rdata;
	ctl_t              ctl;
	logic [IDX_W-1:0]  row;
	logic [IDX_W-1:0]  col;

	assign accept  = start && !busy;
	assign go      = accept && start_req;
	// positions past the right matrix store nothing
	assign l_we    = accept && (element_pos < POS_W'(CELLS));
	assign r_we    = accept && (element_pos >= POS_W'(CELLS))
		&& (int'(element_pos) < 2 * CELLS);
	assign l_waddr = element_pos[CELL_W-1:0];
	assign r_waddr = CELL_W'(element_pos - POS_W'(CELLS));

	mm4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (element_value),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	mm4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (element_value),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	mm4_seq #(.DIM(DIM)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.busy   (busy),
		.ctl    (ctl),
		.row    (row),
		.col    (col),
		.l_addr (l_raddr),
		.r_addr (r_raddr)
	);

	mm4_dp #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.row           (row),
		.col           (col),
		.l_data        ($signed(l_rdata)),
		.r_data        ($signed(r_rdata)),
		.result_strobe (result_strobe),
		.result_value  (result_value),
		.result_row    (result_row),
		.result_col    (result_col),
		.saturated     (saturated),
		.last_result   (last_result)
	);

endmodule

// ===== rtl/core/mm4_chk.sv =====
// port-level checker for the matrix multiplier, bound to the top level
module mm4_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic start_req,
	input logic result_strobe,
	input logic last_result
);

	// a run starts on a start beat
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && start_req |=> busy)
		else $error("run did not start");

	// results only come out of a run
	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result outside a run");

	// the final beat ends the run, any other keeps it going
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_result |-> !busy)
		else $error("busy after last result");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |-> busy)
		else $error("run ended early");

	// results never come back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("results back to back");

endmodule

bind matrix_multiply_4x4 mm4_chk u_mm4_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.start_req     (start_req),
	.result_strobe (result_strobe),
	.last_result   (last_result)
);
